[hw/rtl/ecp_pkg.sv]
// Package: shared types and constants for the embedded controller host port.
package ecp_pkg;

    localparam int ADDR_WIDTH  = 8;
    localparam int SPACE_DEPTH = 1 << ADDR_WIDTH;

    localparam logic [7:0] CMD_READ  = 8'h80;
    localparam logic [7:0] CMD_WRITE = 8'h81;
    localparam logic [7:0] STS_OBF   = 8'h01;
    localparam logic [7:0] STS_CMD   = 8'h08;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CMD  = 1'b1;

    typedef struct packed {
        logic       command;
        logic       port_select;
        logic [7:0] write_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       protocol_error;
    } t_out_word;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RADDR = 2'd1,
        PH_WADDR = 2'd2,
        PH_WDATA = 2'd3
    } t_phase;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_FILL = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        RD_ZERO   = 2'd0,
        RD_STATUS = 2'd1,
        RD_OBUF   = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        logic    err;
        logic    clr_obf;
        logic    set_cmd;
        logic    clr_cmd;
        logic    latch_addr;
        logic    mem_rd;
        logic    mem_wr;
        logic    fill;
    } t_dp_cmd;

endpackage

[hw/rtl/ecp_ifs.sv]
// Interfaces: host access channel and response channel.
interface ecp_in_if;
    logic              valid;
    logic              ready;
    ecp_pkg::t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface ecp_out_if;
    logic               valid;
    logic               ready;
    ecp_pkg::t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

[hw/rtl/ecp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ecp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ecp_ctrl.sv]
// Controller: handshake, command sequence phase and datapath commands.
module ecp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  ecp_pkg::t_in_word i_in_word,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ecp_pkg::t_dp_cmd  o_cmd
);

    ecp_pkg::t_state r_state, n_state;
    ecp_pkg::t_phase r_phase, n_phase;
    logic            r_out_valid, n_out_valid;
    logic            w_accept;

    assign o_in_ready  = (r_state == ecp_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ecp_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    if (i_in_word.command == ecp_pkg::ACC_WRITE) begin
                        if (i_in_word.port_select == ecp_pkg::PORT_CMD) begin
                            if (i_in_word.write_byte == ecp_pkg::CMD_READ) begin
                                n_phase = ecp_pkg::PH_RADDR;
                            end else if (i_in_word.write_byte == ecp_pkg::CMD_WRITE) begin
                                n_phase = ecp_pkg::PH_WADDR;
                            end else begin
                                n_phase = ecp_pkg::PH_IDLE;
                            end
                        end else begin
                            case (r_phase)
                                ecp_pkg::PH_RADDR: begin
                                    n_phase = ecp_pkg::PH_IDLE;
                                    n_state = ecp_pkg::ST_FILL;
                                end
                                ecp_pkg::PH_WADDR: n_phase = ecp_pkg::PH_WDATA;
                                ecp_pkg::PH_WDATA: n_phase = ecp_pkg::PH_IDLE;
                                default:           n_phase = ecp_pkg::PH_IDLE;
                            endcase
                        end
                    end
                end
            end
            ecp_pkg::ST_FILL: n_state = ecp_pkg::ST_IDLE;
            default:          n_state = ecp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = ecp_pkg::RD_ZERO;
        o_cmd.fill   = (r_state == ecp_pkg::ST_FILL);
        if (w_accept) begin
            o_cmd.load = 1'b1;
            if (i_in_word.command == ecp_pkg::ACC_READ) begin
                if (i_in_word.port_select == ecp_pkg::PORT_CMD) begin
                    o_cmd.rd_sel = ecp_pkg::RD_STATUS;
                end else begin
                    o_cmd.rd_sel  = ecp_pkg::RD_OBUF;
                    o_cmd.clr_obf = 1'b1;
                end
            end else if (i_in_word.port_select == ecp_pkg::PORT_CMD) begin
                o_cmd.set_cmd = 1'b1;
                o_cmd.err     = (i_in_word.write_byte != ecp_pkg::CMD_READ) &&
                                (i_in_word.write_byte != ecp_pkg::CMD_WRITE);
            end else begin
                o_cmd.clr_cmd = 1'b1;
                case (r_phase)
                    ecp_pkg::PH_RADDR: o_cmd.mem_rd     = 1'b1;
                    ecp_pkg::PH_WADDR: o_cmd.latch_addr = 1'b1;
                    ecp_pkg::PH_WDATA: o_cmd.mem_wr     = 1'b1;
                    default:           o_cmd.err        = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ecp_pkg::ST_IDLE;
            r_phase     <= ecp_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_fill_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ecp_pkg::ST_FILL |=> r_state == ecp_pkg::ST_IDLE)
        else $error("fill state held more than one cycle");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted word produced no result");

    a_fill_enters_from_raddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ecp_pkg::ST_FILL) |-> $past(r_phase) == ecp_pkg::PH_RADDR)
        else $error("fill started outside a read address phase");
`endif

endmodule

[hw/rtl/ecp_dp.sv]
// Datapath: register space, address latch, output buffer, status bits, result register.
module ecp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecp_pkg::t_dp_cmd   i_cmd,
    input  logic [7:0]         i_byte,
    output ecp_pkg::t_out_word o_word
);

    logic [ecp_pkg::ADDR_WIDTH-1:0] r_addr;
    logic [7:0]                     r_obuf;
    logic                           r_obf;
    logic                           r_cmd;
    logic                           r_rd_valid;
    logic                           r_valid [ecp_pkg::SPACE_DEPTH];
    logic [7:0]                     r_read_byte, n_read_byte;
    logic                           r_error;
    logic [7:0]                     w_ram_q;
    logic [ecp_pkg::ADDR_WIDTH-1:0] w_raddr;

    assign w_raddr = i_byte[ecp_pkg::ADDR_WIDTH-1:0];

    ecp_ram #(
        .WIDTH (8),
        .DEPTH (ecp_pkg::SPACE_DEPTH)
    ) u_space (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_waddr (r_addr),
        .i_wdata (i_byte),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_comb begin
        case (i_cmd.rd_sel)
            ecp_pkg::RD_STATUS: n_read_byte = (r_obf ? ecp_pkg::STS_OBF : 8'h00) |
                                              (r_cmd ? ecp_pkg::STS_CMD : 8'h00);
            ecp_pkg::RD_OBUF:   n_read_byte = r_obuf;
            default:            n_read_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_addr) begin
            r_addr <= i_byte[ecp_pkg::ADDR_WIDTH-1:0];
        end
        if (i_cmd.mem_rd) begin
            r_rd_valid <= r_valid[w_raddr];
        end
        if (i_cmd.load) begin
            r_read_byte <= n_read_byte;
            r_error     <= i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obuf <= 8'h00;
            r_obf  <= 1'b0;
            r_cmd  <= 1'b0;
            for (int i = 0; i < ecp_pkg::SPACE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.mem_wr) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (i_cmd.fill) begin
                r_obuf <= r_rd_valid ? w_ram_q : 8'h00;
                r_obf  <= 1'b1;
            end else if (i_cmd.clr_obf) begin
                r_obf <= 1'b0;
            end
            if (i_cmd.set_cmd) begin
                r_cmd <= 1'b1;
            end else if (i_cmd.clr_cmd) begin
                r_cmd <= 1'b0;
            end
        end
    end

    assign o_word.read_byte      = r_read_byte;
    assign o_word.protocol_error = r_error;

endmodule

[hw/rtl/embedded_controller_host_port.sv]
// Top level: embedded controller host port, device side.
//
//  channel  | dir | payload                                 | handshake
//  i_host   | in  | command, port_select, write_byte        | valid/ready
//  o_resp   | out | read_byte, protocol_error               | valid/ready
//
// One host access per cycle unless the result stalls or a fill is pending; a
// read sequence's data write adds a fill state for the registered space read.
// Reset clears the phase, status bits, output buffer and per-entry valid bits
// at once; no clearing pass is needed.
// A new access is taken while the result register is full if it drains that cycle.
module embedded_controller_host_port (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ecp_in_if.sink    i_host,
    ecp_out_if.source o_resp
);

    ecp_pkg::t_dp_cmd w_cmd;
    logic             w_in_ready;
    logic             w_out_valid;

    ecp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_host.valid),
        .i_in_word   (i_host.word),
        .i_out_ready (o_resp.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    ecp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_byte  (i_host.word.write_byte),
        .o_word  (o_resp.word)
    );

    assign i_host.ready = w_in_ready;
    assign o_resp.valid = w_out_valid;

endmodule
